FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deframer check failed");

// Clocked property that is also checked during reset.
`define ASSERT_NORST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("deframer reset check failed");

`endif

FILE: hw/rtl/crcdf_pkg.sv
// Package for the CRC-16 packet deframer: types, codes and the CRC step.
package crcdf_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
  localparam logic [1:0] REG_EXP_VERSION   = 2'd2;
  localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [5:0] {
    PH_SYNC1   = 6'b000001,
    PH_SYNC2   = 6'b000010,
    PH_HEADER  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRCLO   = 6'b010000,
    PH_CRCHI   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] expected_version;
    logic [7:0] payload_limit;
  } cfg_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/crcdf_ifs.sv
// Valid/ready channel interfaces for received bytes and deframer results.
interface crcdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

interface crcdf_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_position;
  logic [7:0]  message_type;
  logic [15:0] sequence_number;
  logic [7:0]  packet_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_position, output message_type,
                  output sequence_number, output packet_length, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_position, input message_type,
                  input sequence_number, input packet_length, output ready);
  modport mon    (input valid, input result_kind, input payload_byte,
                  input payload_position, input message_type,
                  input sequence_number, input packet_length, input ready);
endinterface

FILE: hw/rtl/crcdf_cfg.sv
// APB register file holding the deframer's sync, version and length settings.
module crcdf_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crcdf_pkg::AddrW-1:0] paddr,
  input  logic [crcdf_pkg::DataW-1:0] pwdata,
  output logic [crcdf_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output crcdf_pkg::cfg_t             cfg_o
);

  crcdf_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;
  logic [1:0]      reg_idx;
  logic [7:0]      rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        crcdf_pkg::REG_SYNC_FIRST:    cfg_d.sync_first       = pwdata[7:0];
        crcdf_pkg::REG_SYNC_SECOND:   cfg_d.sync_second      = pwdata[7:0];
        crcdf_pkg::REG_EXP_VERSION:   cfg_d.expected_version = pwdata[7:0];
        crcdf_pkg::REG_PAYLOAD_LIMIT: cfg_d.payload_limit    = pwdata[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      crcdf_pkg::REG_SYNC_FIRST:    rd_val = cfg_q.sync_first;
      crcdf_pkg::REG_SYNC_SECOND:   rd_val = cfg_q.sync_second;
      crcdf_pkg::REG_EXP_VERSION:   rd_val = cfg_q.expected_version;
      crcdf_pkg::REG_PAYLOAD_LIMIT: rd_val = cfg_q.payload_limit;
      default:                      rd_val = 8'h00;
    endcase
  end

  assign prdata = {{(crcdf_pkg::DataW-8){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first       <= 8'h00;
      cfg_q.sync_second      <= 8'h00;
      cfg_q.expected_version <= 8'h00;
      cfg_q.payload_limit    <= 8'hFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/crc16_packet_deframer.sv
// Top level of the byte-serial packet deframer with CRC-16/CCITT-FALSE check.
//
// rx_i carries one received byte per word. The deframer hunts for the two
// sync bytes, collects a 5-byte header (version, type, sequence LE, length),
// forwards each payload byte as a result word, then checks the LE CRC-16
// over header and payload and reports packet good or packet dropped on res_o.
// Settings live in an APB register file: sync_first at 0x0, sync_second at
// 0x4, expected_version at 0x8, payload_limit at 0xC.
//
// One byte is accepted per cycle; its result word, if any, appears on res_o
// the cycle after acceptance. The full CRC byte update and the frame state
// step are combinational between the input handshake and the result register.
// When res_o is stalled with a word held, rx_i.ready drops until the word is
// taken; bytes that give no result still need the result register free.
// Reset puts the deframer back in the hunt for the first sync byte, empties
// the result register and restores the register defaults (limit 255).
module crc16_packet_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  crcdf_byte_if.sink                  rx_i,
  crcdf_res_if.source                 res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crcdf_pkg::AddrW-1:0] paddr,
  input  logic [crcdf_pkg::DataW-1:0] pwdata,
  output logic [crcdf_pkg::DataW-1:0] prdata,
  output logic                        pready
);

  crcdf_pkg::cfg_t   cfg;
  crcdf_pkg::phase_e phase_q, phase_d;
  logic [2:0]        hdr_cnt_q, hdr_cnt_d;
  logic [7:0]        type_q, type_d;
  logic [15:0]       seq_q, seq_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        pay_cnt_q, pay_cnt_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crc_lo_q, crc_lo_d;
  logic              vbad_q, vbad_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic [7:0]        pbyte_q, pbyte_d;
  logic [7:0]        ppos_q, ppos_d;
  logic [7:0]        mtype_q, mtype_d;
  logic [15:0]       mseq_q, mseq_d;
  logic [7:0]        mlen_q, mlen_d;

  logic              accept;
  logic              emit;
  logic [7:0]        b;
  logic [15:0]       crc_next;
  logic [7:0]        pay_cnt_inc;

  crcdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign accept      = rx_i.valid && rx_i.ready;
  assign b           = rx_i.rx_byte;
  assign crc_next    = crcdf_pkg::crc_byte(crc_q, b);
  assign pay_cnt_inc = pay_cnt_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    type_d    = type_q;
    seq_d     = seq_q;
    len_d     = len_q;
    pay_cnt_d = pay_cnt_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    vbad_d    = vbad_q;
    emit      = 1'b0;
    kind_d    = crcdf_pkg::KIND_PAYLOAD;
    pbyte_d   = 8'h00;
    ppos_d    = 8'h00;
    mtype_d   = 8'h00;
    mseq_d    = 16'h0000;
    mlen_d    = 8'h00;

    if (accept) begin
      case (phase_q)
        crcdf_pkg::PH_SYNC2: begin
          if (b == cfg.sync_second) begin
            hdr_cnt_d = 3'd0;
            crc_d     = crcdf_pkg::CRC_INIT;
            vbad_d    = 1'b0;
            phase_d   = crcdf_pkg::PH_HEADER;
          end else begin
            phase_d = (b == cfg.sync_first) ? crcdf_pkg::PH_SYNC2 : crcdf_pkg::PH_SYNC1;
          end
        end
        crcdf_pkg::PH_HEADER: begin
          crc_d = crc_next;
          case (hdr_cnt_q)
            3'd0:    vbad_d = (b != cfg.expected_version);
            3'd1:    type_d = b;
            3'd2:    seq_d  = {seq_q[15:8], b};
            3'd3:    seq_d  = {b, seq_q[7:0]};
            default: len_d  = b;
          endcase
          if (hdr_cnt_q >= 3'd4) begin
            if (vbad_q || (b > cfg.payload_limit)) begin
              phase_d   = crcdf_pkg::PH_SYNC1;
              hdr_cnt_d = 3'd0;
              type_d    = 8'h00;
              seq_d     = 16'h0000;
              len_d     = 8'h00;
              pay_cnt_d = 8'h00;
              crc_d     = crcdf_pkg::CRC_INIT;
              crc_lo_d  = 8'h00;
              vbad_d    = 1'b0;
              emit      = 1'b1;
              kind_d    = crcdf_pkg::KIND_DROP;
            end else begin
              hdr_cnt_d = 3'd0;
              pay_cnt_d = 8'h00;
              phase_d   = (b == 8'h00) ? crcdf_pkg::PH_CRCLO : crcdf_pkg::PH_PAYLOAD;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        crcdf_pkg::PH_PAYLOAD: begin
          crc_d     = crc_next;
          pay_cnt_d = pay_cnt_inc;
          if (pay_cnt_inc == len_q) begin
            phase_d = crcdf_pkg::PH_CRCLO;
          end
          emit    = 1'b1;
          kind_d  = crcdf_pkg::KIND_PAYLOAD;
          pbyte_d = b;
          ppos_d  = pay_cnt_q;
        end
        crcdf_pkg::PH_CRCLO: begin
          crc_lo_d = b;
          phase_d  = crcdf_pkg::PH_CRCHI;
        end
        crcdf_pkg::PH_CRCHI: begin
          emit = 1'b1;
          if ({b, crc_lo_q} == crc_q) begin
            kind_d  = crcdf_pkg::KIND_GOOD;
            mtype_d = type_q;
            mseq_d  = seq_q;
            mlen_d  = len_q;
          end else begin
            kind_d = crcdf_pkg::KIND_DROP;
          end
          phase_d   = crcdf_pkg::PH_SYNC1;
          hdr_cnt_d = 3'd0;
          type_d    = 8'h00;
          seq_d     = 16'h0000;
          len_d     = 8'h00;
          pay_cnt_d = 8'h00;
          crc_d     = crcdf_pkg::CRC_INIT;
          crc_lo_d  = 8'h00;
          vbad_d    = 1'b0;
        end
        default: begin
          // hunting the first sync byte, also for any stray phase code
          phase_d = (b == cfg.sync_first) ? crcdf_pkg::PH_SYNC2 : crcdf_pkg::PH_SYNC1;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= crcdf_pkg::PH_SYNC1;
      hdr_cnt_q   <= 3'd0;
      type_q      <= 8'h00;
      seq_q       <= 16'h0000;
      len_q       <= 8'h00;
      pay_cnt_q   <= 8'h00;
      crc_q       <= crcdf_pkg::CRC_INIT;
      crc_lo_q    <= 8'h00;
      vbad_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      type_q      <= type_d;
      seq_q       <= seq_d;
      len_q       <= len_d;
      pay_cnt_q   <= pay_cnt_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      vbad_q      <= vbad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new word
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      ppos_q  <= ppos_d;
      mtype_q <= mtype_d;
      mseq_q  <= mseq_d;
      mlen_q  <= mlen_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.result_kind      = kind_q;
  assign res_o.payload_byte     = pbyte_q;
  assign res_o.payload_position = ppos_q;
  assign res_o.message_type     = mtype_q;
  assign res_o.sequence_number  = mseq_q;
  assign res_o.packet_length    = mlen_q;

endmodule

FILE: hw/rtl/crcdf_checker.sv
// Port-level checks for the packet deframer, bound to its top level.
`include "assert_macros.svh"

module crcdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  res_kind_i,
  input logic [7:0]  res_byte_i,
  input logic [7:0]  res_pos_i,
  input logic [7:0]  res_type_i,
  input logic [15:0] res_seq_i,
  input logic [7:0]  res_len_i
);

  logic        res_stall;
  logic        res_not_pay;
  logic [49:0] res_word;
  logic [15:0] res_pay_fields;

  assign res_stall      = res_valid_i && !res_ready_i;
  assign res_not_pay    = res_valid_i && (res_kind_i != crcdf_pkg::KIND_PAYLOAD);
  assign res_word       = {res_kind_i, res_byte_i, res_pos_i, res_type_i, res_seq_i,
                           res_len_i};
  assign res_pay_fields = {res_byte_i, res_pos_i};

  // a stalled result word holds
  `ASSERT_PROP(a_res_hold, res_stall |=> res_valid_i && $stable(res_word))

  // no result word comes out of reset
  `ASSERT_NORST(a_res_reset, !rst_ni |-> !res_valid_i)

  `ASSERT_PROP(a_kind_known, res_valid_i |-> res_kind_i <= crcdf_pkg::KIND_DROP)

  // only payload words carry payload fields
  `ASSERT_PROP(a_pay_zero, res_not_pay |-> res_pay_fields == 16'h0000)

  // an empty result register never blocks input
  `ASSERT_PROP(a_rx_open, !res_valid_i |-> rx_ready_i)

endmodule

bind crc16_packet_deframer crcdf_checker u_crcdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_ready_i  (rx_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.result_kind),
  .res_byte_i  (res_o.payload_byte),
  .res_pos_i   (res_o.payload_position),
  .res_type_i  (res_o.message_type),
  .res_seq_i   (res_o.sequence_number),
  .res_len_i   (res_o.packet_length)
);
